// ----- hw/rtl/grid_occupancy_region_query_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the grid occupancy block
// Clocked on clk, disabled while arst_n is low; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef GRID_OCCUPANCY_REGION_QUERY_ASSERT_SVH
`define GRID_OCCUPANCY_REGION_QUERY_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge.
`define GOR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("grid occupancy check failed");
// Check that a condition holds in the cycle after a trigger.
`define GOR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid occupancy sequence check failed");
`else
`define GOR_ASSERT(lbl, prop)
`define GOR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/gor_pkg.sv -----
// ---------------------------------------------------------------------------
// gor_pkg
// Shared types and constants of the grid occupancy region query block.
// ---------------------------------------------------------------------------
package gor_pkg;

	localparam int COORD_W    = 16;	// signed Q12.4 coordinate
	localparam int INV_W      = 16;	// UQ0.16 reciprocal
	localparam int PROD_W     = COORD_W + INV_W;
	localparam int FRAC_SHIFT = 20;	// 4 + 16 fraction bits in the product
	localparam int VAL_W      = PROD_W - FRAC_SHIFT;
	localparam int MEMBER_W   = 8;
	localparam int CELL_W     = 3;	// width of reported row and column

	typedef enum logic [1:0] {
		OP_ASSIGN = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_QUERY  = 2'd3
	} gor_op_t;

	typedef enum logic [0:0] {
		CFG_INV_CELL_WIDTH  = 1'b0,
		CFG_INV_CELL_HEIGHT = 1'b1
	} gor_cfg_idx_t;

	// Index result of the coordinate unit: truncated magnitude with negatives
	// folded to zero, and a flag for a strictly negative index.
	typedef struct packed {
		logic             vld;
		logic [VAL_W-1:0] val;
		logic             negz;
	} gor_idx_t;

endpackage

// ----- hw/rtl/gor_ifs.sv -----
// ---------------------------------------------------------------------------
// gor request and response channels
// Valid/ready channels carrying one operation and one result item.
// ---------------------------------------------------------------------------
interface gor_req_if;
	logic                                      valid;
	logic                                      ready;
	gor_pkg::gor_op_t                          op;
	logic signed [gor_pkg::COORD_W-1:0]        x_low;
	logic signed [gor_pkg::COORD_W-1:0]        y_low;
	logic signed [gor_pkg::COORD_W-1:0]        x_high;
	logic signed [gor_pkg::COORD_W-1:0]        y_high;
	logic [gor_pkg::MEMBER_W-1:0]              member_id;

	modport source (output valid, op, x_low, y_low, x_high, y_high, member_id, input ready);
	modport sink (input valid, op, x_low, y_low, x_high, y_high, member_id, output ready);
endinterface

interface gor_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [gor_pkg::CELL_W-1:0]    cell_row;
	logic [gor_pkg::CELL_W-1:0]    cell_col;
	logic [gor_pkg::MEMBER_W-1:0]  cell_member;
	logic                          hit;
	logic                          last;

	modport source (output valid, cell_row, cell_col, cell_member, hit, last, input ready);
	modport sink (input valid, cell_row, cell_col, cell_member, hit, last, output ready);
endinterface

// ----- hw/rtl/grid_occupancy_region_query.sv -----
// Grid occupancy map with box query.
// Requests arrive on req (valid/ready): assign and remove set or clear the cell
// that a Q12.4 position maps to, clear empties the grid, query reports every
// occupied cell inside a box. Results leave on rsp (valid/ready), one per
// transfer, with last marking the final result of a request.
// One request is processed at a time; req.ready is high only while idle.
// A single multiplier converts one coordinate per cycle, and the query scan
// looks at one grid row per cycle while its row holds no hit. Steps per request:
//   clear:          result straight from the idle state
//   assign, remove: two coordinates converted, cell updated, then the result
//   query:          four coordinates converted, span built, then rows scanned;
//                   each hit reads its member id before its result goes out
// Each result is held in an output register until rsp.ready; the scan pauses
// while the receiver stalls. Reset empties every cell and loads both
// reciprocals with 4096; member ids are stored in a RAM and are not cleared.
// Configuration writes are registered and are expected only while idle.
// ---------------------------------------------------------------------------
// grid_occupancy_region_query
// Uniform grid spatial partition with assign, remove, clear and box query.
// ---------------------------------------------------------------------------
`include "grid_occupancy_region_query_assert.svh"

module grid_occupancy_region_query #(
	parameter int GRID_ROWS = 8,
	parameter int GRID_COLS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  gor_pkg::gor_cfg_idx_t        cfg_index,
	input  logic [gor_pkg::INV_W-1:0]    cfg_wdata,
	gor_req_if.sink                      req,
	gor_rsp_if.source                    rsp
);
	import gor_pkg::*;

	localparam int NCELLS = GRID_ROWS * GRID_COLS;
	localparam int IDX_W  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
	localparam int RW     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int CW     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int NCOORD = 4;
	localparam int STEP_W = 3;
	// coordinate slots: even slots are columns (x), odd slots are rows (y)
	localparam int CO_XLO = 0;
	localparam int CO_YLO = 1;
	localparam int CO_XHI = 2;
	localparam int CO_YHI = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_APPLY,
		ST_SPAN,
		ST_SCAN,
		ST_READ,
		ST_OUT
	} state_t;

	state_t                     state_q;
	gor_op_t                    op_q;
	logic signed [COORD_W-1:0]  coord_q [NCOORD];
	logic [MEMBER_W-1:0]        member_q;
	logic [STEP_W-1:0]          step_q;
	logic [VAL_W-1:0]           val_q [NCOORD];
	logic [1:0]                 negz_q;	// x_high, y_high strictly negative
	logic [NCELLS-1:0]          occ_q;
	logic [NCELLS-1:0]          rem_q;	// occupied cells of the span not yet reported
	logic [RW-1:0]              row_q;
	logic [INV_W-1:0]           inv_w_q;
	logic [INV_W-1:0]           inv_h_q;

	logic [RW-1:0]              out_row_q;
	logic [CW-1:0]              out_col_q;
	logic [MEMBER_W-1:0]        out_member_q;
	logic                       out_hit_q;
	logic                       out_last_q;

	// shared coordinate unit
	logic                       unit_start;
	logic signed [COORD_W-1:0]  unit_coord;
	logic [INV_W-1:0]           unit_inv;
	gor_idx_t                   unit_res;
	logic [STEP_W-1:0]          nsteps;
	logic [1:0]                 cur_sel;
	logic [1:0]                 tag;

	// assign / remove target
	logic [RW-1:0]              a_row;
	logic [CW-1:0]              a_col;
	logic [IDX_W-1:0]           a_idx;

	// query span and scan
	logic [GRID_ROWS-1:0]       row_in;
	logic [GRID_COLS-1:0]       col_in;
	logic [NCELLS-1:0]          span;
	logic [GRID_COLS-1:0]       row_bits;
	logic [CW-1:0]              pick_col;
	logic                       found;
	logic [IDX_W-1:0]           s_idx;
	logic [NCELLS-1:0]          rem_clr;

	// owner RAM
	logic                       ram_we;
	logic                       ram_re;
	logic [MEMBER_W-1:0]        ram_rdata;

	// -----------------------------------------------------------------------
	// Configuration registers
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_w_q <= INV_W'(4096);
			inv_h_q <= INV_W'(4096);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INV_CELL_WIDTH:  inv_w_q <= cfg_wdata;
				CFG_INV_CELL_HEIGHT: inv_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Coordinate sequencing: two coordinates for assign/remove, four for a
	// query; the unit result for step n-1 returns while step n is issued.
	// -----------------------------------------------------------------------
	always_comb begin
		nsteps     = (op_q == OP_QUERY) ? STEP_W'(NCOORD) : STEP_W'(2);
		cur_sel    = step_q[1:0];
		tag        = 2'(step_q - STEP_W'(1));
		unit_start = (state_q == ST_CALC) && (step_q < nsteps);
		unit_coord = coord_q[cur_sel];
		unit_inv   = cur_sel[0] ? inv_h_q : inv_w_q;
	end

	gor_coord_unit u_coord (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.coord  (unit_coord),
		.inv    (unit_inv),
		.res    (unit_res)
	);

	// -----------------------------------------------------------------------
	// Assign / remove target: clamp to the last row and column
	// -----------------------------------------------------------------------
	always_comb begin
		a_row = (val_q[CO_YLO] > VAL_W'(GRID_ROWS - 1)) ? RW'(GRID_ROWS - 1)
			: val_q[CO_YLO][RW-1:0];
		a_col = (val_q[CO_XLO] > VAL_W'(GRID_COLS - 1)) ? CW'(GRID_COLS - 1)
			: val_q[CO_XLO][CW-1:0];
		a_idx = IDX_W'(a_row * GRID_COLS + a_col);
	end

	// -----------------------------------------------------------------------
	// Query span mask. Low bounds are already raised to zero; a high bound
	// beyond the grid needs no clamp, a negative one empties the span.
	// -----------------------------------------------------------------------
	always_comb begin
		for (int r = 0; r < GRID_ROWS; r++) begin
			row_in[r] = (VAL_W'(r) >= val_q[CO_YLO]) && (VAL_W'(r) <= val_q[CO_YHI])
				&& !negz_q[1];
		end
		for (int c = 0; c < GRID_COLS; c++) begin
			col_in[c] = (VAL_W'(c) >= val_q[CO_XLO]) && (VAL_W'(c) <= val_q[CO_XHI])
				&& !negz_q[0];
		end
		for (int r = 0; r < GRID_ROWS; r++) begin
			for (int c = 0; c < GRID_COLS; c++) begin
				span[r * GRID_COLS + c] = row_in[r] & col_in[c];
			end
		end
	end

	// -----------------------------------------------------------------------
	// Row scan: lowest remaining column of the current row
	// -----------------------------------------------------------------------
	always_comb begin
		row_bits = rem_q[row_q * GRID_COLS +: GRID_COLS];
		found    = |row_bits;
		pick_col = '0;
		for (int c = GRID_COLS - 1; c >= 0; c--) begin
			if (row_bits[c]) begin
				pick_col = CW'(c);
			end
		end
		s_idx   = IDX_W'(row_q * GRID_COLS + pick_col);
		rem_clr = rem_q & ~(NCELLS'(1) << s_idx);
	end

	// -----------------------------------------------------------------------
	// Member id store
	// -----------------------------------------------------------------------
	assign ram_we = (state_q == ST_APPLY) && (op_q == OP_ASSIGN);
	assign ram_re = (state_q == ST_SCAN) && (rem_q != '0) && found;

	gor_ram #(
		.WIDTH (MEMBER_W),
		.DEPTH (NCELLS)
	) u_owner_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (a_idx),
		.wdata (member_q),
		.re    (ram_re),
		.raddr (s_idx),
		.rdata (ram_rdata)
	);

	// -----------------------------------------------------------------------
	// Sequencer
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_ASSIGN;
			for (int k = 0; k < NCOORD; k++) begin
				coord_q[k] <= '0;
				val_q[k]   <= '0;
			end
			member_q     <= '0;
			step_q       <= '0;
			negz_q       <= '0;
			occ_q        <= '0;
			rem_q        <= '0;
			row_q        <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			out_member_q <= '0;
			out_hit_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q            <= req.op;
						coord_q[CO_XLO] <= req.x_low;
						coord_q[CO_YLO] <= req.y_low;
						coord_q[CO_XHI] <= req.x_high;
						coord_q[CO_YHI] <= req.y_high;
						member_q        <= req.member_id;
						step_q          <= '0;
						if (req.op == OP_CLEAR) begin
							// drop every occupancy bit; owners stay in the RAM
							occ_q        <= '0;
							out_row_q    <= '0;
							out_col_q    <= '0;
							out_member_q <= '0;
							out_hit_q    <= 1'b0;
							out_last_q   <= 1'b1;
							state_q      <= ST_OUT;
						end else begin
							state_q <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					if (unit_res.vld) begin
						val_q[tag] <= unit_res.val;
						if (tag[1]) begin
							negz_q[tag[0]] <= unit_res.negz;
						end
					end
					step_q <= step_q + STEP_W'(1);
					if (step_q == nsteps) begin
						state_q <= (op_q == OP_QUERY) ? ST_SPAN : ST_APPLY;
					end
				end
				ST_APPLY: begin
					occ_q[a_idx] <= (op_q == OP_ASSIGN);
					out_row_q    <= a_row;
					out_col_q    <= a_col;
					out_member_q <= (op_q == OP_ASSIGN) ? member_q : '0;
					out_hit_q    <= 1'b0;
					out_last_q   <= 1'b1;
					state_q      <= ST_OUT;
				end
				ST_SPAN: begin
					rem_q   <= occ_q & span;
					row_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					priority if (rem_q == '0) begin
						// nothing occupied in the span
						out_row_q    <= '0;
						out_col_q    <= '0;
						out_member_q <= '0;
						out_hit_q    <= 1'b0;
						out_last_q   <= 1'b1;
						state_q      <= ST_OUT;
					end else if (found) begin
						rem_q      <= rem_clr;
						out_row_q  <= row_q;
						out_col_q  <= pick_col;
						out_hit_q  <= 1'b1;
						out_last_q <= (rem_clr == '0);
						state_q    <= ST_READ;
					end else begin
						row_q <= row_q + RW'(1);
					end
				end
				ST_READ: begin
					out_member_q <= ram_rdata;
					state_q      <= ST_OUT;
				end
				ST_OUT: begin
					// hold the result until the transfer
					if (rsp.ready) begin
						state_q <= out_last_q ? ST_IDLE : ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Channel outputs
	// -----------------------------------------------------------------------
	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = (state_q == ST_OUT);
	assign rsp.cell_row    = CELL_W'(out_row_q);
	assign rsp.cell_col    = CELL_W'(out_col_q);
	assign rsp.cell_member = out_member_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.last        = out_last_q;

	// -----------------------------------------------------------------------
	// Checks
	// -----------------------------------------------------------------------
	`GOR_ASSERT(a_one_side_active, !(req.ready && rsp.valid))
	`GOR_ASSERT(a_rem_subset_occ, (rem_q & ~occ_q) == '0)
	`GOR_ASSERT(a_hit_is_occupied, (rsp.valid && rsp.hit) |-> occ_q[IDX_W'(out_row_q * GRID_COLS + out_col_q)])
	`GOR_ASSERT(a_last_when_drained, (rsp.valid && rsp.hit) |-> (rsp.last == (rem_q == '0)))
	`GOR_ASSERT_NEXT(a_idle_after_last, rsp.valid && rsp.ready && rsp.last, req.ready)

endmodule

// ----- hw/rtl/gor_ram.sv -----
// ---------------------------------------------------------------------------
// gor_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module gor_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- hw/rtl/gor_coord_unit.sv -----
// ---------------------------------------------------------------------------
// gor_coord_unit
// Shared coordinate-to-index unit: one Q12.4 x UQ0.16 multiply per cycle.
// ---------------------------------------------------------------------------
module gor_coord_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [gor_pkg::COORD_W-1:0] coord,
	input  logic [gor_pkg::INV_W-1:0]          inv,
	output gor_pkg::gor_idx_t                  res
);
	import gor_pkg::*;

	logic [COORD_W:0]   neg_ext;
	logic [COORD_W-1:0] mag;
	logic [PROD_W-1:0]  prod_s1;
	logic               neg_s1;
	logic               vld_s1;
	logic [VAL_W-1:0]   quot;

	// magnitude of the coordinate; the most negative value still fits unsigned
	always_comb begin
		neg_ext = -{coord[COORD_W-1], coord};
		mag     = coord[COORD_W-1] ? neg_ext[COORD_W-1:0] : coord;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PROD_W'(mag) * PROD_W'(inv);
			neg_s1  <= coord[COORD_W-1];
		end
	end

	// truncate toward zero: drop fraction bits of the magnitude
	always_comb begin
		quot     = prod_s1[PROD_W-1:FRAC_SHIFT];
		res.vld  = vld_s1;
		res.val  = neg_s1 ? '0 : quot;
		res.negz = neg_s1 && (quot != '0);
	end
endmodule
